[hw/rtl/line_endpoint_zoom_rotate_core_defines.svh]
// ----------------------------------------------------------------------------
// Line endpoint zoom/rotate core: assertion macros
// Shared property macros for the checker, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_ENDPOINT_ZOOM_ROTATE_CORE_DEFINES_SVH
`define LINE_ENDPOINT_ZOOM_ROTATE_CORE_DEFINES_SVH

// Same-cycle implication.
`define LEZR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lezr check failed");

// Next-cycle implication.
`define LEZR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lezr check failed");

`endif

[hw/rtl/lezr_pkg.sv]
// ----------------------------------------------------------------------------
// Line endpoint zoom/rotate package
// Pipeline depths, register indexes, trigonometric constants and types.
// ----------------------------------------------------------------------------
`default_nettype none

package lezr_pkg;

  localparam int unsigned PIPE_DEPTH   = 23;
  localparam int unsigned HORNER_STEPS = 4;
  localparam int unsigned GEO_DELAY    = 15;

  localparam logic [1:0] CFG_SPIN   = 2'd0;
  localparam logic [1:0] CFG_ZOOM   = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  localparam logic [30:0] HALF_PI    = 31'd1686629713;
  localparam logic [29:0] QUARTER_PI = 30'd843314857;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  typedef struct packed {
    logic [29:0] g;
    logic [29:0] t2;
    logic        swap;
    logic [1:0]  quad;
  } trig_side_t;

  typedef struct packed {
    logic signed [25:0] px;
    logic signed [25:0] py;
    logic signed [21:0] cx;
    logic signed [21:0] cy;
    logic               last;
  } geo_t;

  function automatic logic [6:0] sin_div(input logic [1:0] step);
    case (step)
      2'd0:    return 7'd72;
      2'd1:    return 7'd42;
      2'd2:    return 7'd20;
      default: return 7'd6;
    endcase
  endfunction

  function automatic logic [31:0] sin_rcp(input logic [1:0] step);
    case (step)
      2'd0:    return 32'd59652323;
      2'd1:    return 32'd102261126;
      2'd2:    return 32'd214748364;
      default: return 32'd715827882;
    endcase
  endfunction

  function automatic logic [6:0] cos_div(input logic [1:0] step);
    case (step)
      2'd0:    return 7'd90;
      2'd1:    return 7'd56;
      2'd2:    return 7'd30;
      default: return 7'd12;
    endcase
  endfunction

  function automatic logic [31:0] cos_rcp(input logic [1:0] step);
    case (step)
      2'd0:    return 32'd47721858;
      2'd1:    return 32'd76695844;
      2'd2:    return 32'd143165576;
      default: return 32'd357913941;
    endcase
  endfunction

endpackage

`default_nettype wire

[hw/rtl/line_endpoint_zoom_rotate_core.sv]
// ----------------------------------------------------------------------------
// Line endpoint zoom/rotate core
// Zooms a segment about the screen centre, scales and turns it about its
// midpoint and maps it to Q12.4 screen coordinates.
//
//   Channel  Direction  Handshake            Word
//   in_      input      in_valid/in_ready    segment endpoints, weights, last
//   out_     output     out_valid/out_ready  saturated screen endpoints, last
//   cfg_     input      cfg_valid/cfg_ready  register index and data
//
// One word is accepted in every cycle unless the output word waits; each result
// passes through the sine/cosine cell chain and the output stages.
// Reset clears the pipeline valid bits and loads the register defaults.
// While the output word waits, the whole pipeline holds and in_ready is low.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module line_endpoint_zoom_rotate_core
  import lezr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_start_x,
  input  wire logic signed [15:0] in_start_y,
  input  wire logic signed [15:0] in_end_x,
  input  wire logic signed [15:0] in_end_y,
  input  wire logic [15:0]        in_scale_weight,
  input  wire logic [14:0]        in_turn_weight,
  input  wire logic               in_last_line,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_start_x,
  output logic signed [15:0]      out_start_y,
  output logic signed [15:0]      out_end_x,
  output logic signed [15:0]      out_end_y,
  output logic                    out_last_out,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  logic [15:0] spin_r, zoom_r;
  logic [11:0] width_r, height_r;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic adv;

  logic signed [33:0] zxs_r, zys_r, zxe_r, zye_r;
  logic [31:0] m1_r, m2_r;
  logic last1_r, last2_r, last3_r;
  logic signed [21:0] cx2_r, cy2_r, hx2_r, hy2_r;
  logic signed [21:0] cx3_r, cy3_r, hx3_r, hy3_r;
  logic signed [54:0] hmx_r, hmy_r;
  logic signed [34:0] sxc_w, syc_w, sxh_w, syh_w;
  logic signed [54:0] hrx_w, hry_w;
  geo_t g4_r;
  geo_t dly_r [GEO_DELAY];
  logic signed [31:0] sin_w, cos_w;

  logic signed [57:0] pc_r, ps_r, qs_r, qc_r;
  logic signed [21:0] cx5_r, cy5_r;
  logic last5_r, last6_r, last7_r;
  logic signed [58:0] sx_w, sy_w;
  logic signed [29:0] xs_r, ys_r, xe_r, ye_r;
  logic signed [42:0] mxs_r, mys_r, mxe_r, mye_r;
  logic signed [15:0] oxs_r, oys_r, oxe_r, oye_r;
  logic olast_r;

  function automatic logic signed [33:0] zoom_pt(input logic signed [15:0] p,
                                                input logic [15:0] z);
    logic signed [16:0] d;
    d = 17'(p) - 17'sd8192;
    return (34'(d) * $signed({18'b0, z})) + 34'sd134217728;
  endfunction

  function automatic logic signed [28:0] rnd30(input logic signed [58:0] v);
    logic signed [58:0] b;
    b = v + 59'sd536870912;
    return $signed(b[58:30]);
  endfunction

  function automatic logic signed [15:0] to_screen(input logic signed [42:0] v);
    logic signed [42:0] b;
    logic signed [30:0] r;
    b = v + 43'sd2048;
    r = $signed(b[42:12]);
    if (r > 31'sd32767) begin
      return 16'sd32767;
    end else if (r < -31'sd32768) begin
      return -16'sd32768;
    end
    return 16'(r);
  endfunction

  assign adv       = !vld_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_r   <= 16'd0;
      zoom_r   <= 16'd16384;
      width_r  <= 12'd320;
      height_r <= 12'd240;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SPIN:   spin_r   <= cfg_data;
        CFG_ZOOM:   zoom_r   <= cfg_data;
        CFG_WIDTH:  width_r  <= cfg_data[11:0];
        CFG_HEIGHT: height_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  assign sxc_w = 35'(zxs_r) + 35'(zxe_r) + 35'sd4096;
  assign syc_w = 35'(zys_r) + 35'(zye_r) + 35'sd4096;
  assign sxh_w = 35'(zxs_r) - 35'(zxe_r) + 35'sd4096;
  assign syh_w = 35'(zys_r) - 35'(zye_r) + 35'sd4096;
  assign hrx_w = hmx_r + 55'sd536870912;
  assign hry_w = hmy_r + 55'sd536870912;

  always_ff @(posedge clk) begin
    if (adv) begin
      zxs_r   <= zoom_pt(in_start_x, zoom_r);
      zys_r   <= zoom_pt(in_start_y, zoom_r);
      zxe_r   <= zoom_pt(in_end_x, zoom_r);
      zye_r   <= zoom_pt(in_end_y, zoom_r);
      m1_r    <= 32'(in_scale_weight) * 32'(spin_r);
      last1_r <= in_last_line;

      cx2_r   <= $signed(sxc_w[34:13]);
      cy2_r   <= $signed(syc_w[34:13]);
      hx2_r   <= $signed(sxh_w[34:13]);
      hy2_r   <= $signed(syh_w[34:13]);
      m2_r    <= m1_r;
      last2_r <= last1_r;

      hmx_r   <= 55'(hx2_r) * $signed({23'b0, m2_r});
      hmy_r   <= 55'(hy2_r) * $signed({23'b0, m2_r});
      hx3_r   <= hx2_r;
      hy3_r   <= hy2_r;
      cx3_r   <= cx2_r;
      cy3_r   <= cy2_r;
      last3_r <= last2_r;

      g4_r.px   <= 26'(hx3_r) + 26'($signed(hrx_w[54:30]));
      g4_r.py   <= 26'(hy3_r) + 26'($signed(hry_w[54:30]));
      g4_r.cx   <= cx3_r;
      g4_r.cy   <= cy3_r;
      g4_r.last <= last3_r;

      dly_r[0] <= g4_r;
      for (int i = 1; i < GEO_DELAY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  lezr_sincos u_sincos (
    .clk         (clk),
    .adv         (adv),
    .turn_weight (in_turn_weight),
    .spin        (spin_r),
    .sin_o       (sin_w),
    .cos_o       (cos_w)
  );

  assign sx_w = 59'(pc_r) + 59'(ps_r);
  assign sy_w = 59'(qc_r) - 59'(qs_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      pc_r    <= 58'(dly_r[GEO_DELAY-1].px) * 58'(cos_w);
      ps_r    <= 58'(dly_r[GEO_DELAY-1].py) * 58'(sin_w);
      qs_r    <= 58'(dly_r[GEO_DELAY-1].px) * 58'(sin_w);
      qc_r    <= 58'(dly_r[GEO_DELAY-1].py) * 58'(cos_w);
      cx5_r   <= dly_r[GEO_DELAY-1].cx;
      cy5_r   <= dly_r[GEO_DELAY-1].cy;
      last5_r <= dly_r[GEO_DELAY-1].last;

      xs_r    <= 30'(rnd30(sx_w)) + 30'(cx5_r);
      xe_r    <= 30'(rnd30(-sx_w)) + 30'(cx5_r);
      ys_r    <= 30'(rnd30(sy_w)) + 30'(cy5_r);
      ye_r    <= 30'(rnd30(-sy_w)) + 30'(cy5_r);
      last6_r <= last5_r;

      mxs_r   <= 43'(xs_r) * $signed({31'b0, width_r});
      mxe_r   <= 43'(xe_r) * $signed({31'b0, width_r});
      mys_r   <= 43'(ys_r) * $signed({31'b0, height_r});
      mye_r   <= 43'(ye_r) * $signed({31'b0, height_r});
      last7_r <= last6_r;

      oxs_r   <= to_screen(mxs_r);
      oys_r   <= to_screen(mys_r);
      oxe_r   <= to_screen(mxe_r);
      oye_r   <= to_screen(mye_r);
      olast_r <= last7_r;
    end
  end

  assign out_valid    = vld_r[PIPE_DEPTH-1];
  assign out_start_x  = oxs_r;
  assign out_start_y  = oys_r;
  assign out_end_x    = oxe_r;
  assign out_end_y    = oye_r;
  assign out_last_out = olast_r;

endmodule

`default_nettype wire

[hw/rtl/lezr_hcell.sv]
// ----------------------------------------------------------------------------
// Horner cell
// One series step for sine and cosine: multiply, divide by constant, subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module lezr_hcell
  import lezr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        adv,
  input  wire logic [1:0]  step,
  input  wire trig_side_t  side_i,
  input  wire logic [30:0] ts_i,
  input  wire logic [30:0] tc_i,
  output trig_side_t       side_o,
  output logic [30:0]      ts_o,
  output logic [30:0]      tc_o
);

  trig_side_t  side_a_r, side_b_r, side_c_r;
  logic [29:0] ps_a_r, pc_a_r;
  logic [29:0] ps_b_r, pc_b_r, qs_b_r, qc_b_r;
  logic [30:0] ts_c_r, tc_c_r;

  logic [60:0] mul_s, mul_c;
  logic [61:0] rcp_s, rcp_c;
  logic [36:0] rem_s, rem_c;
  logic [29:0] qfix_s, qfix_c;

  assign mul_s = 61'(side_i.t2) * 61'(ts_i);
  assign mul_c = 61'(side_i.t2) * 61'(tc_i);
  assign rcp_s = 62'(ps_a_r) * 62'(sin_rcp(step));
  assign rcp_c = 62'(pc_a_r) * 62'(cos_rcp(step));
  assign rem_s = 37'(ps_b_r) - 37'(qs_b_r) * 37'(sin_div(step));
  assign rem_c = 37'(pc_b_r) - 37'(qc_b_r) * 37'(cos_div(step));
  assign qfix_s = (rem_s >= 37'(sin_div(step))) ? qs_b_r + 30'd1 : qs_b_r;
  assign qfix_c = (rem_c >= 37'(cos_div(step))) ? qc_b_r + 30'd1 : qc_b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      side_a_r <= side_i;
      ps_a_r   <= mul_s[59:30];
      pc_a_r   <= mul_c[59:30];
      side_b_r <= side_a_r;
      ps_b_r   <= ps_a_r;
      pc_b_r   <= pc_a_r;
      qs_b_r   <= rcp_s[61:32];
      qc_b_r   <= rcp_c[61:32];
      side_c_r <= side_b_r;
      ts_c_r   <= ONE_Q30 - {1'b0, qfix_s};
      tc_c_r   <= ONE_Q30 - {1'b0, qfix_c};
    end
  end

  assign side_o = side_c_r;
  assign ts_o   = ts_c_r;
  assign tc_o   = tc_c_r;

endmodule

`default_nettype wire

[hw/rtl/lezr_sincos.sv]
// ----------------------------------------------------------------------------
// Sine/cosine unit
// Angle product, range reduction, octant fold and a chain of Horner cells.
// ----------------------------------------------------------------------------
`default_nettype none

module lezr_sincos
  import lezr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic [14:0]        turn_weight,
  input  wire logic [15:0]        spin,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);

  localparam logic [32:0] K1 = {2'b00, HALF_PI};
  localparam logic [32:0] K2 = {1'b0, HALF_PI, 1'b0};
  localparam logic [32:0] K3 = K1 + K2;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic [30:0] ang_r, red_r, frac_r;
  logic [1:0]  quad_r, quad4_r;
  logic [29:0] g_r;
  logic        swap_r;
  logic [32:0] a_w, off_w, f_w;
  logic [1:0]  quad_w;
  logic        swap_w;
  logic [30:0] g_w;
  logic [59:0] gg_w;

  trig_side_t  side_w [HORNER_STEPS+1];
  logic [30:0] ts_w   [HORNER_STEPS+1];
  logic [30:0] tc_w   [HORNER_STEPS+1];
  trig_side_t  side0_r;

  logic [60:0] fin_s, fin_c;
  logic [30:0] ms_r, mc_r;
  logic        swap_f_r;
  logic [1:0]  quad_f_r;
  logic [30:0] cg_w, sf_w, cf_w;
  logic signed [31:0] sf_s, cf_s;
  logic signed [31:0] sin_r, cos_r;

  assign a_w = {red_r, 2'b00};

  always_comb begin
    if (a_w >= K3) begin
      quad_w = QUAD_3;
      off_w  = K3;
    end else if (a_w >= K2) begin
      quad_w = QUAD_2;
      off_w  = K2;
    end else if (a_w >= K1) begin
      quad_w = QUAD_1;
      off_w  = K1;
    end else begin
      quad_w = QUAD_0;
      off_w  = '0;
    end
  end

  assign f_w    = a_w - off_w;
  assign swap_w = frac_r > {1'b0, QUARTER_PI};
  assign g_w    = swap_w ? HALF_PI - frac_r : frac_r;
  assign gg_w   = 60'(g_r) * 60'(g_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r   <= 31'(turn_weight) * 31'(spin);
      red_r   <= (ang_r >= HALF_PI) ? ang_r - HALF_PI : ang_r;
      frac_r  <= f_w[30:0];
      quad_r  <= quad_w;
      g_r     <= g_w[29:0];
      swap_r  <= swap_w;
      quad4_r <= quad_r;
      side0_r <= '{g: g_r, t2: gg_w[59:30], swap: swap_r, quad: quad4_r};
    end
  end

  assign side_w[0] = side0_r;
  assign ts_w[0]   = ONE_Q30;
  assign tc_w[0]   = ONE_Q30;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_cell
    lezr_hcell u_cell (
      .clk    (clk),
      .adv    (adv),
      .step   (2'(i)),
      .side_i (side_w[i]),
      .ts_i   (ts_w[i]),
      .tc_i   (tc_w[i]),
      .side_o (side_w[i+1]),
      .ts_o   (ts_w[i+1]),
      .tc_o   (tc_w[i+1])
    );
  end

  assign fin_s = 61'(side_w[HORNER_STEPS].g) * 61'(ts_w[HORNER_STEPS]);
  assign fin_c = 61'(side_w[HORNER_STEPS].t2) * 61'(tc_w[HORNER_STEPS]);

  assign cg_w = ONE_Q30 - (mc_r >> 1);
  assign sf_w = swap_f_r ? cg_w : ms_r;
  assign cf_w = swap_f_r ? ms_r : cg_w;
  assign sf_s = $signed({1'b0, sf_w});
  assign cf_s = $signed({1'b0, cf_w});

  always_ff @(posedge clk) begin
    if (adv) begin
      ms_r     <= fin_s[60:30];
      mc_r     <= fin_c[60:30];
      swap_f_r <= side_w[HORNER_STEPS].swap;
      quad_f_r <= side_w[HORNER_STEPS].quad;
      unique case (quad_f_r)
        QUAD_0: begin
          sin_r <= sf_s;
          cos_r <= cf_s;
        end
        QUAD_1: begin
          sin_r <= cf_s;
          cos_r <= -sf_s;
        end
        QUAD_2: begin
          sin_r <= -sf_s;
          cos_r <= -cf_s;
        end
        default: begin
          sin_r <= -cf_s;
          cos_r <= sf_s;
        end
      endcase
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

`default_nettype wire

[hw/rtl/lezr_checker.sv]
// ----------------------------------------------------------------------------
// Line endpoint zoom/rotate checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_endpoint_zoom_rotate_core_defines.svh"

module lezr_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] out_start_x,
  input wire logic signed [15:0] out_start_y,
  input wire logic signed [15:0] out_end_x,
  input wire logic signed [15:0] out_end_y,
  input wire logic               out_last_out,
  input wire logic               cfg_ready
);

  logic [64:0] out_word;

  assign out_word = {out_start_x, out_start_y, out_end_x, out_end_y, out_last_out};

  `LEZR_ASSERT_IMP(a_ready_when_free, !out_valid || out_ready, in_ready)
  `LEZR_ASSERT_IMP(a_block_when_full, out_valid && !out_ready, !in_ready)
  `LEZR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  `LEZR_ASSERT_IMP(a_cfg_open, 1'b1, cfg_ready)

endmodule

bind line_endpoint_zoom_rotate_core lezr_checker u_lezr_checker (.*);

`default_nettype wire
